/* design/mbe_pkg.sv */
// ----------------------------------------------------------------------------
// mbe_pkg: shared types, constants and functions of the escape-time colorer
// Fixed-point formats, register indexes, the color ramp and small helpers.
// ----------------------------------------------------------------------------
package mbe_pkg;

   // Sizing
   localparam int ITER_BITS       = 16;
   localparam int COORD_FRAC_BITS = 28;
   localparam int PIXEL_BITS      = 12;

   // Queue between front and core
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Coordinate products in the front
   localparam int CPROD_BITS = PIXEL_BITS + 31;
   localparam int CSUM_BITS  = CPROD_BITS + 1;

   // Multiplier: quotient width after the smaller shift
   localparam int MUL_QW = 129 - COORD_FRAC_BITS;

   // Gradient position: 4 integer bits (segment) and 16 fraction bits
   localparam int GRAD_FRAC_BITS = 16;
   localparam int DIV_STEPS      = GRAD_FRAC_BITS + 4;
   localparam int DCNT_BITS      = $clog2(DIV_STEPS);
   localparam int ATX_BITS       = ITER_BITS + 4;

   localparam logic signed [63:0] FOUR_FIX = 64'sd4 <<< COORD_FRAC_BITS;
   localparam logic signed [63:0] S64_MAX  = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN  = {1'b1, {63{1'b0}}};

   // Register indexes
   localparam logic [2:0] CSR_START_REAL = 3'd0;
   localparam logic [2:0] CSR_START_IMAG = 3'd1;
   localparam logic [2:0] CSR_STEP_REAL  = 3'd2;
   localparam logic [2:0] CSR_STEP_IMAG  = 3'd3;
   localparam logic [2:0] CSR_ITER_LIMIT = 3'd4;

   // Register reset values
   localparam logic signed [31:0] START_REAL_RST = 32'shE000_0000;
   localparam logic signed [31:0] START_IMAG_RST = 32'sh2000_0000;
   localparam logic [30:0]        STEP_REAL_RST  = 31'd262144;
   localparam logic [30:0]        STEP_IMAG_RST  = 31'd262144;
   localparam logic [15:0]        ITER_LIMIT_RST = 16'd256;

   // One queued point c
   typedef struct packed {
      logic signed [31:0] cr;
      logic signed [31:0] ci;
   } mbe_point_type;

   // Request to the shared multiplier
   typedef struct packed {
      logic               go;
      logic               half;   // shift by one bit less (2*x*y)
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mbe_mul_req_type;

   // Saturating 64-bit signed add
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] sum;
      begin
         sum = a + b;
         if (a[63] == b[63] && sum[63] != a[63]) begin
            sum = a[63] ? S64_MIN : S64_MAX;
         end
         return sum;
      end
   endfunction

   // Gradient ramp, eleven knots packed as {r, g, b}
   function automatic logic [23:0] ramp_rgb(input logic [3:0] idx);
      logic [23:0] rgb;
      begin
         case (idx)
            4'd0, 4'd4, 4'd8: rgb = 24'hff0000;
            4'd1, 4'd5, 4'd9: rgb = 24'h00ff00;
            4'd2, 4'd6:       rgb = 24'h0000ff;
            4'd3, 4'd7:       rgb = 24'hffff00;
            default:          rgb = 24'h000000;
         endcase
         return rgb;
      end
   endfunction

   // Linear blend of one channel, truncated
   function automatic logic [7:0] blend8(input logic [7:0] c0, input logic [7:0] c1,
                                         input logic [GRAD_FRAC_BITS-1:0] fr);
      logic signed [8:0]  diff;
      logic signed [25:0] prod;
      logic signed [25:0] val;
      begin
         diff = $signed({1'b0, c1}) - $signed({1'b0, c0});
         prod = 26'(diff) * $signed({10'd0, fr});
         val  = $signed({2'b00, c0, 16'd0}) + prod;
         return val[23:16];
      end
   endfunction

endpackage

/* design/mbe_mul.sv */
// ----------------------------------------------------------------------------
// mbe_mul: iterative 64x64 signed fixed-point multiplier
// Four 32x32 partial products on magnitudes, then floor shift and saturate.
// ----------------------------------------------------------------------------
module mbe_mul import mbe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mbe_mul_req_type    mul_req,
   output logic               mul_done,
   output logic signed [63:0] mul_result
);

   typedef enum logic [1:0] {M_IDLE, M_ACC, M_ROUND, M_SAT} mstate_type;

   mstate_type          state_ff;
   logic [63:0]         ua_ff, ub_ff;
   logic                neg_ff, half_ff;
   logic [1:0]          k_ff;
   logic [127:0]        acc_ff;
   logic [MUL_QW-1:0]   q_ff;
   logic                done_ff;
   logic signed [63:0]  result_ff;

   logic [31:0]  a_part, b_part;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [127:0] shifted;
   logic         rem;

   // Select partial product operands and weight
   always_comb begin
      a_part = k_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      b_part = k_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      pp     = {32'd0, a_part} * {32'd0, b_part};
      case (k_ff)
         2'd0:    pp_sh = {64'd0, pp};
         2'd3:    pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
   end

   // Floor shift with remainder flag
   always_comb begin
      if (half_ff) begin
         shifted = acc_ff >> (COORD_FRAC_BITS - 1);
         rem     = |acc_ff[COORD_FRAC_BITS-2:0];
      end else begin
         shifted = acc_ff >> COORD_FRAC_BITS;
         rem     = |acc_ff[COORD_FRAC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         unique case (state_ff)
            M_IDLE: begin
               if (mul_req.go) begin
                  ua_ff    <= mul_req.a[63] ? 64'(-mul_req.a) : 64'(mul_req.a);
                  ub_ff    <= mul_req.b[63] ? 64'(-mul_req.b) : 64'(mul_req.b);
                  neg_ff   <= mul_req.a[63] ^ mul_req.b[63];
                  half_ff  <= mul_req.half;
                  k_ff     <= 2'd0;
                  acc_ff   <= '0;
                  state_ff <= M_ACC;
               end
            end
            M_ACC: begin
               acc_ff <= acc_ff + pp_sh;
               k_ff   <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_ff <= M_ROUND;
               end
            end
            M_ROUND: begin
               q_ff     <= MUL_QW'(shifted) + MUL_QW'(neg_ff & rem);
               state_ff <= M_SAT;
            end
            M_SAT: begin
               if (|q_ff[MUL_QW-1:63]) begin
                  result_ff <= neg_ff ? S64_MIN : S64_MAX;
               end else begin
                  result_ff <= neg_ff ? -$signed(q_ff[63:0]) : $signed(q_ff[63:0]);
               end
               done_ff  <= 1'b1;
               state_ff <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign mul_done   = done_ff;
   assign mul_result = result_ff;

endmodule

/* design/mbe_front.sv */
// ----------------------------------------------------------------------------
// mbe_front: pixel intake and point queue
// Forms c from column and row, saturates it, and queues it for the core.
// ----------------------------------------------------------------------------
module mbe_front import mbe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [11:0]           req_column,
   input  logic [11:0]           req_row,
   input  logic signed [31:0]    start_real,
   input  logic signed [31:0]    start_imag,
   input  logic [30:0]           step_real,
   input  logic [30:0]           step_imag,
   input  logic                  pop,
   output logic                  point_valid,
   output mbe_point_type         point
);

   localparam logic signed [CSUM_BITS-1:0] S32_MAX = CSUM_BITS'(32'sh7fff_ffff);
   localparam logic signed [CSUM_BITS-1:0] S32_MIN = -(CSUM_BITS'(33'sh0_8000_0000));

   mbe_point_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;

   logic [CPROD_BITS-1:0]       prod_r, prod_i;
   logic signed [CSUM_BITS-1:0] sum_r, sum_i;
   mbe_point_type               new_point;
   logic                        push;

   // Form c = (start_real + col*step_real, start_imag - row*step_imag)
   always_comb begin
      prod_r = CPROD_BITS'(req_column[PIXEL_BITS-1:0]) * CPROD_BITS'(step_real);
      prod_i = CPROD_BITS'(req_row[PIXEL_BITS-1:0]) * CPROD_BITS'(step_imag);
      sum_r  = CSUM_BITS'(start_real) + $signed({1'b0, prod_r});
      sum_i  = CSUM_BITS'(start_imag) - $signed({1'b0, prod_i});
      if (sum_r > S32_MAX)      new_point.cr = 32'sh7fff_ffff;
      else if (sum_r < S32_MIN) new_point.cr = 32'sh8000_0000;
      else                      new_point.cr = sum_r[31:0];
      if (sum_i > S32_MAX)      new_point.ci = 32'sh7fff_ffff;
      else if (sum_i < S32_MIN) new_point.ci = 32'sh8000_0000;
      else                      new_point.ci = sum_i[31:0];
   end

   assign busy        = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign push        = start && !busy;
   assign point_valid = (count_ff != '0);
   assign point       = entry_ff[rd_ptr_ff];

   // Hold queued points
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_point;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> point_valid)
      else $error("pop from an empty point queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("point queue overfilled");

endmodule

/* design/mbe_core.sv */
// ----------------------------------------------------------------------------
// mbe_core: escape-time iteration, gradient division and coloring
// Runs z = z^2 + c on the shared multiplier, then picks the pixel color.
// ----------------------------------------------------------------------------
module mbe_core import mbe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 point_valid,
   input  mbe_point_type        point,
   output logic                 pop,
   input  logic [ITER_BITS-1:0] iter_limit,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue,
   output logic                 rsp_escaped,
   output logic [15:0]          rsp_escape_step
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_WAIT_XY, S_ISSUE_RR, S_WAIT_RR,
      S_ISSUE_II, S_WAIT_II, S_DIV, S_COLOR
   } cstate_type;

   cstate_type           state_ff;
   logic signed [31:0]   cr_ff, ci_ff;
   logic signed [63:0]   zr_ff, zi_ff, zr2_ff, zi2_ff;
   logic [ITER_BITS-1:0] iter_ff, at_ff;
   logic [ITER_BITS-1:0] rem_ff;
   logic [DIV_STEPS-1:0] num_ff, quo_ff;
   logic [DCNT_BITS-1:0] dcnt_ff;
   logic                 valid_ff, escaped_ff;
   logic [7:0]           red_ff, green_ff, blue_ff;
   logic [15:0]          step_ff;

   mbe_mul_req_type     mul_req;
   logic                mul_done;
   logic signed [63:0]  mul_result;

   logic signed [63:0]   sum_sq;
   logic                 escape_hit, at_last;
   logic [ATX_BITS-1:0]  atx10;
   logic [ITER_BITS:0]   rem_sh, rem_sub;
   logic                 ge;
   logic [3:0]           seg;
   logic [GRAD_FRAC_BITS-1:0] frac;
   logic [23:0]          rgb0, rgb1;

   mbe_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .mul_req    (mul_req),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   // Escape test and loop end
   always_comb begin
      sum_sq     = sat_add64(zr2_ff, zi2_ff);
      escape_hit = (sum_sq >= FOUR_FIX);
      at_last    = (iter_ff == iter_limit);
      atx10      = (ATX_BITS'(iter_ff) << 3) + (ATX_BITS'(iter_ff) << 1);
   end

   // Drive the multiplier
   always_comb begin
      mul_req.go   = 1'b0;
      mul_req.half = 1'b0;
      mul_req.a    = zr_ff;
      mul_req.b    = zr_ff;
      case (state_ff)
         S_CHECK: begin
            mul_req.go   = !at_last && !escape_hit;
            mul_req.half = 1'b1;
            mul_req.b    = zi_ff;
         end
         S_ISSUE_RR: mul_req.go = 1'b1;
         S_ISSUE_II: begin
            mul_req.go = 1'b1;
            mul_req.a  = zi_ff;
            mul_req.b  = zi_ff;
         end
         default: ;
      endcase
   end

   // Restoring division step
   always_comb begin
      rem_sh  = {rem_ff, num_ff[DIV_STEPS-1]};
      ge      = (rem_sh >= {1'b0, iter_limit});
      rem_sub = rem_sh - {1'b0, iter_limit};
      seg     = quo_ff[DIV_STEPS-1:GRAD_FRAC_BITS];
      frac    = quo_ff[GRAD_FRAC_BITS-1:0];
      rgb0    = ramp_rgb(seg);
      rgb1    = ramp_rgb(seg + 4'd1);
   end

   assign pop = (state_ff == S_IDLE) && point_valid;

   always_ff @(posedge clock) begin
      valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            // Take the next point and clear the orbit
            S_IDLE: begin
               if (point_valid) begin
                  cr_ff    <= point.cr;
                  ci_ff    <= point.ci;
                  zr_ff    <= '0;
                  zi_ff    <= '0;
                  zr2_ff   <= '0;
                  zi2_ff   <= '0;
                  iter_ff  <= '0;
                  state_ff <= S_CHECK;
               end
            end
            // Test for escape or end of the limit
            S_CHECK: begin
               if (at_last) begin
                  red_ff     <= '0;
                  green_ff   <= '0;
                  blue_ff    <= '0;
                  escaped_ff <= 1'b0;
                  step_ff    <= '0;
                  valid_ff   <= 1'b1;
                  state_ff   <= S_IDLE;
               end else if (escape_hit) begin
                  at_ff    <= iter_ff;
                  rem_ff   <= atx10[ATX_BITS-1:4];
                  num_ff   <= {atx10[3:0], {GRAD_FRAC_BITS{1'b0}}};
                  dcnt_ff  <= '0;
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_WAIT_XY;
               end
            end
            // New zi from 2*zr*zi, new zr from the squares
            S_WAIT_XY: begin
               if (mul_done) begin
                  zi_ff    <= sat_add64(mul_result, 64'(ci_ff));
                  zr_ff    <= sat_add64(zr2_ff - zi2_ff, 64'(cr_ff));
                  state_ff <= S_ISSUE_RR;
               end
            end
            S_ISSUE_RR: state_ff <= S_WAIT_RR;
            S_WAIT_RR: begin
               if (mul_done) begin
                  zr2_ff   <= mul_result;
                  state_ff <= S_ISSUE_II;
               end
            end
            S_ISSUE_II: state_ff <= S_WAIT_II;
            S_WAIT_II: begin
               if (mul_done) begin
                  zi2_ff   <= mul_result;
                  iter_ff  <= iter_ff + 1'b1;
                  state_ff <= S_CHECK;
               end
            end
            // One quotient bit per cycle of 10*i*2^16 / limit
            S_DIV: begin
               rem_ff  <= ge ? rem_sub[ITER_BITS-1:0] : rem_sh[ITER_BITS-1:0];
               num_ff  <= {num_ff[DIV_STEPS-2:0], 1'b0};
               quo_ff  <= {quo_ff[DIV_STEPS-2:0], ge};
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DCNT_BITS'(DIV_STEPS - 1)) begin
                  state_ff <= S_COLOR;
               end
            end
            // Blend between the two knots of the segment
            S_COLOR: begin
               red_ff     <= blend8(rgb0[23:16], rgb1[23:16], frac);
               green_ff   <= blend8(rgb0[15:8], rgb1[15:8], frac);
               blue_ff    <= blend8(rgb0[7:0], rgb1[7:0], frac);
               escaped_ff <= 1'b1;
               step_ff    <= 16'(at_ff);
               valid_ff   <= 1'b1;
               state_ff   <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_escaped     = escaped_ff;
   assign rsp_escape_step = step_ff;

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat lasted more than one cycle");

   a_black_inner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_escaped |->
         rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0 &&
         rsp_escape_step == 16'd0)
      else $error("bounded pixel not black");

   a_escape_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_escaped |-> rsp_escape_step != 16'd0)
      else $error("escape at step zero");

   a_mul_idle_go: assert property (@(posedge clock) disable iff (reset)
      mul_req.go |-> !$past(mul_req.go))
      else $error("multiplier started twice in a row");

endmodule

/* design/mandelbrot_escape_color_top.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_color_top: escape-time pixel colorer
// Maps a pixel to c, iterates z = z^2 + c and returns a gradient color.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_column/req_row with start; the beat is taken when start
//   is high and busy is low. A two-entry point queue sits between the intake
//   and the iteration core, so busy rises only when both entries are full.
//   Output: one result beat per pixel, rsp_valid high for one cycle with the
//   color, escaped flag and escape step. The receiver cannot stall; results
//   come in input order.
//   Config: csr_we/csr_index/csr_wdata write start, step and limit registers;
//   write only while no pixel is in flight. Indexes above four are ignored.
// Timing:
//   Each iteration is paced by the shared 32x32 multiplier, which builds
//   three 64-bit products (four partial products each) in turn. A pixel
//   runs n iterations (n up to the limit), then goes through division and
//   coloring when it escapes.
// Reset: synchronous; empties the queue, idles the core and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_color_top import mbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_escaped,
   output logic [15:0] rsp_escape_step,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic signed [31:0]   start_real_ff, start_imag_ff;
   logic [30:0]          step_real_ff, step_imag_ff;
   logic [15:0]          iter_limit_ff;

   logic                 pop, point_valid;
   mbe_point_type        point;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_real_ff <= START_REAL_RST;
         start_imag_ff <= START_IMAG_RST;
         step_real_ff  <= STEP_REAL_RST;
         step_imag_ff  <= STEP_IMAG_RST;
         iter_limit_ff <= ITER_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_REAL: start_real_ff <= csr_wdata;
            CSR_START_IMAG: start_imag_ff <= csr_wdata;
            CSR_STEP_REAL:  step_real_ff  <= csr_wdata[30:0];
            CSR_STEP_IMAG:  step_imag_ff  <= csr_wdata[30:0];
            CSR_ITER_LIMIT: iter_limit_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   mbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_column  (req_column),
      .req_row     (req_row),
      .start_real  (start_real_ff),
      .start_imag  (start_imag_ff),
      .step_real   (step_real_ff),
      .step_imag   (step_imag_ff),
      .pop         (pop),
      .point_valid (point_valid),
      .point       (point)
   );

   mbe_core u_core (
      .clock           (clock),
      .reset           (reset),
      .point_valid     (point_valid),
      .point           (point),
      .pop             (pop),
      .iter_limit      (ITER_BITS'(iter_limit_ff)),
      .rsp_valid       (rsp_valid),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_escaped     (rsp_escaped),
      .rsp_escape_step (rsp_escape_step)
   );

endmodule
